// ===== rtl/sacl_pkg.sv =====
// Shared constants, types and the LFSR step for the cache tag lookup.
package sacl_pkg;

	localparam int NUM_WAYS    = 8;
	localparam int NUM_SETS    = 64;
	localparam int OFFSET_BITS = 6;
	localparam int ADDR_BITS   = 32;

	localparam int WAY_BITS  = $clog2(NUM_WAYS);
	localparam int SET_BITS  = $clog2(NUM_SETS);
	localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - SET_BITS;
	localparam int LFSR_BITS = 16;
	localparam int CNT_BITS  = 32;

	localparam logic [LFSR_BITS-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [LFSR_BITS-1:0] SEED_RESET = 16'h0001;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef struct packed {
		logic                valid;
		logic [TAG_BITS-1:0] tag;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the address and read its set
		logic flush;  // clear valid rows, counters and results, reload the LFSR
		logic update; // resolve the lookup and write the set back
	} cmd_t;

	function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
		logic [LFSR_BITS-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

// ===== rtl/sacl_ctrl.sv =====
// Controller state machine: accepts items and sequences the datapath.
module sacl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               operation,
	output logic               busy,
	output logic               done,
	output sacl_pkg::cmd_t     cmd
);
	import sacl_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept     = start && !busy_q;
	assign cmd.load   = accept && (operation == OP_ACCESS);
	assign cmd.flush  = accept && (operation == OP_FLUSH);
	assign cmd.update = (state_q == ST_LOOKUP);

	assign busy = busy_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= cmd.flush;
					if (cmd.load) begin
						state_q <= ST_LOOKUP;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q == ST_LOOKUP))
		else $error("busy disagrees with the controller state");

	a_lookup_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> done_q && !busy_q)
		else $error("lookup did not deliver its item");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> done_q && !busy_q)
		else $error("flush did not deliver its item");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.flush && !cmd.update |=> !done_q)
		else $error("result strobe without a finished item");

endmodule

// ===== rtl/sacl_dp.sv =====
// Datapath: set memory, tag compare, victim choice, LFSR and counters.
module sacl_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sacl_pkg::cmd_t                  cmd,
	input  logic [sacl_pkg::ADDR_BITS-1:0]  address,
	input  logic                            cfg_we,
	input  logic [sacl_pkg::LFSR_BITS-1:0]  cfg_wdata,
	output logic                            hit,
	output logic [sacl_pkg::WAY_BITS-1:0]   way,
	output logic                            evicted,
	output logic [sacl_pkg::SET_BITS-1:0]   set_index,
	output logic [sacl_pkg::TAG_BITS-1:0]   tag_value,
	output logic [sacl_pkg::CNT_BITS-1:0]   hit_count,
	output logic [sacl_pkg::CNT_BITS-1:0]   miss_count
);
	import sacl_pkg::*;

	// One row per set holds every way's valid bit and tag.
	row_t mem [NUM_SETS];
	// A row whose bit is clear has never been written since the last flush.
	logic [NUM_SETS-1:0] row_valid_q;

	logic [LFSR_BITS-1:0] seed_q;
	logic [LFSR_BITS-1:0] lfsr_q;
	logic [CNT_BITS-1:0]  hits_q;
	logic [CNT_BITS-1:0]  misses_q;

	logic [SET_BITS-1:0] set_in;
	logic [TAG_BITS-1:0] tag_in;
	logic [SET_BITS-1:0] set_s1;
	logic [TAG_BITS-1:0] tag_s1;
	row_t                rdata_s1;
	logic                rv_s1;

	logic                hit_q;
	logic [WAY_BITS-1:0] way_q;
	logic                evicted_q;
	logic [SET_BITS-1:0] set_q;
	logic [TAG_BITS-1:0] tag_q;

	row_t                 cur_row;
	row_t                 new_row;
	logic                 lk_hit;
	logic [WAY_BITS-1:0]  lk_hit_way;
	logic                 lk_free;
	logic [WAY_BITS-1:0]  lk_free_way;
	logic [LFSR_BITS-1:0] lfsr_adv;
	logic [WAY_BITS-1:0]  lk_way;

	assign set_in = address[OFFSET_BITS +: SET_BITS];
	assign tag_in = address[ADDR_BITS-1 -: TAG_BITS];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_s1 <= mem[set_in];
			set_s1   <= set_in;
			tag_s1   <= tag_in;
		end
		if (cmd.update) begin
			mem[set_s1] <= new_row;
		end
	end

	// Compare all ways at once; the lowest matching and lowest free way win.
	always_comb begin
		cur_row     = rv_s1 ? rdata_s1 : '0;
		lk_hit      = 1'b0;
		lk_hit_way  = '0;
		lk_free     = 1'b0;
		lk_free_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (cur_row[w].valid && cur_row[w].tag == tag_s1) begin
				lk_hit     = 1'b1;
				lk_hit_way = WAY_BITS'(w);
			end
			if (!cur_row[w].valid) begin
				lk_free     = 1'b1;
				lk_free_way = WAY_BITS'(w);
			end
		end
		lfsr_adv = lfsr_next(lfsr_q);
		if (lk_hit) begin
			lk_way = lk_hit_way;
		end else if (lk_free) begin
			lk_way = lk_free_way;
		end else begin
			lk_way = lfsr_adv[WAY_BITS-1:0];
		end
		new_row = cur_row;
		if (!lk_hit) begin
			new_row[lk_way].valid = 1'b1;
			new_row[lk_way].tag   = tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rv_s1       <= 1'b0;
			seed_q      <= SEED_RESET;
			lfsr_q      <= SEED_RESET;
			hits_q      <= '0;
			misses_q    <= '0;
			hit_q       <= 1'b0;
			way_q       <= '0;
			evicted_q   <= 1'b0;
			set_q       <= '0;
			tag_q       <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rv_s1 <= row_valid_q[set_in];
			end
			if (cmd.flush) begin
				row_valid_q <= '0;
				// A zero seed would lock the LFSR up.
				lfsr_q      <= (seed_q == '0) ? SEED_RESET : seed_q;
				hits_q      <= '0;
				misses_q    <= '0;
				hit_q       <= 1'b0;
				way_q       <= '0;
				evicted_q   <= 1'b0;
				set_q       <= '0;
				tag_q       <= '0;
			end else if (cmd.update) begin
				row_valid_q[set_s1] <= 1'b1;
				hit_q     <= lk_hit;
				way_q     <= lk_way;
				evicted_q <= !lk_hit && !lk_free;
				set_q     <= set_s1;
				tag_q     <= tag_s1;
				if (lk_hit) begin
					if (hits_q != '1) begin
						hits_q <= hits_q + 1'b1;
					end
				end else begin
					if (misses_q != '1) begin
						misses_q <= misses_q + 1'b1;
					end
					if (!lk_free) begin
						lfsr_q <= lfsr_adv;
					end
				end
			end
		end
	end

	assign hit        = hit_q;
	assign way        = way_q;
	assign evicted    = evicted_q;
	assign set_index  = set_q;
	assign tag_value  = tag_q;
	assign hit_count  = hits_q;
	assign miss_count = misses_q;

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> hits_q == '0 && misses_q == '0 && row_valid_q == '0)
		else $error("flush left counters or valid rows set");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("replacement LFSR has locked at zero");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!(evicted_q && hit_q))
		else $error("an item reports both a hit and an eviction");

endmodule

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// Top level of the set-associative cache tag lookup.
// An item is taken when start is high and busy is low. A flush answers with done in the cycle
// after it is taken; an access reads its set, and its result appears with done after the
// registered read of the set memory and the compare-and-write-back state that follows it.
// Busy stays high through that state, so no new item is taken before the access is through.
// Results are shown for exactly one cycle with done and cannot be held off. No clearing pass is
// needed after reset. The seed written on cfg_we is loaded into the LFSR at the next flush.
module set_assoc_cache_tag_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [sacl_pkg::ADDR_BITS-1:0]  address,
	input  logic                            cfg_we,
	input  logic [sacl_pkg::LFSR_BITS-1:0]  cfg_wdata,
	output logic                            done,
	output logic                            hit,
	output logic [sacl_pkg::WAY_BITS-1:0]   way,
	output logic                            evicted,
	output logic [sacl_pkg::SET_BITS-1:0]   set_index,
	output logic [sacl_pkg::TAG_BITS-1:0]   tag_value,
	output logic [sacl_pkg::CNT_BITS-1:0]   hit_count,
	output logic [sacl_pkg::CNT_BITS-1:0]   miss_count
);
	import sacl_pkg::*;

	cmd_t cmd;

	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	sacl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.address    (address),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.hit        (hit),
		.way        (way),
		.evicted    (evicted),
		.set_index  (set_index),
		.tag_value  (tag_value),
		.hit_count  (hit_count),
		.miss_count (miss_count)
	);

endmodule
